// ===== src/crs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_pkg
// Shared widths, opcodes, status codes and a helper for the spline evaluator.
// ----------------------------------------------------------------------------
package crs_pkg;

    // Default store depth
    localparam int MAX_POINTS_DEF = 64;

    // Field widths
    localparam int OP_W     = 2;
    localparam int COORD_W  = 32;
    localparam int POINT_W  = 3 * COORD_W;
    localparam int T_W      = 17;
    localparam int STATUS_W = 3;

    // Arithmetic widths: basis coefficients, running value, multiply-add sum
    localparam int COEF_W = COORD_W + 5;
    localparam int H_W    = COORD_W + 6;
    localparam int SUM_W  = H_W + T_W + 1;

    // Q1.16 one
    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    // Opcodes
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_EVAL   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_POS_OK  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FEW     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STORED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

    // Axis select within a packed point {x, y, z}
    function automatic logic signed [COORD_W-1:0] coord_of(
        input logic [POINT_W-1:0] w,
        input logic [1:0]         ax
    );
        logic signed [COORD_W-1:0] c;
        unique case (ax)
            2'd0:    c = w[3*COORD_W-1:2*COORD_W];
            2'd1:    c = w[2*COORD_W-1:COORD_W];
            default: c = w[COORD_W-1:0];
        endcase
        return c;
    endfunction

endpackage

// ===== src/crs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_req_if / crs_rsp_if
// Valid/ready channels for spline commands and results.
// ----------------------------------------------------------------------------
interface crs_req_if;
    import crs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            op;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;
    logic [T_W-1:0]             param_t;

    modport source (output valid, op, point_x, point_y, point_z, param_t, input ready);
    modport sink   (input valid, op, point_x, point_y, point_z, param_t, output ready);
endinterface

interface crs_rsp_if;
    import crs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, pos_x, pos_y, pos_z, status, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, status, output ready);
endinterface

// ===== src/catmull_rom_spline_eval_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval_core
// Control point store and uniform Catmull-Rom evaluator, signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transfer: append a point, clear the store,
//   or evaluate the curve at param_t (Q1.16, 65536 = 1.0). Opcode 3 is
//   ignored and gives no result. rsp returns one result per command.
//   Append, clear, and evaluate with fewer than four points skip the
//   arithmetic and go straight to the output load state S_FIN.
//   Evaluate: segment select, 4 store reads plus a drain state, then per
//   axis a coefficient state and 3 multiply-add steps (S_MUL, then S_ADD)
//   on one shared 38x18 multiplier, then the output load in S_FIN. In
//   every case rsp.valid rises once the output register is loaded, and the
//   next command is taken only after that load.
//   req.ready is high only while idle; one command is processed at a time.
//   A finished result sits in the output register; a new command is taken
//   while it waits, but the next result holds until rsp is drained.
//   Reset empties the store (count to zero) and drops any pending result.
// ----------------------------------------------------------------------------
module catmull_rom_spline_eval_core #(
    parameter int MAX_POINTS = crs_pkg::MAX_POINTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    crs_req_if.sink      req,
    crs_rsp_if.source    rsp
);
    import crs_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int TOT_W = T_W + CNT_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SEG   = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_DRAIN = 8'b0000_1000,
        S_COEF  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_ADD   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    // Control state
    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [1:0]         rd_cnt_reg;
    logic               cap_reg;
    logic [1:0]         axis_reg;
    logic [1:0]         step_reg;
    logic               out_valid_reg;

    // Payload
    logic [T_W-1:0]             t_reg;
    logic [IDX_W-1:0]           seg_reg;
    logic [T_W-1:0]             u_reg;
    logic [POINT_W-1:0]         rd_data_reg;
    logic [POINT_W-1:0]         p_reg [4];
    logic signed [COEF_W-1:0]   b_reg;
    logic signed [COEF_W-1:0]   c_reg;
    logic signed [COEF_W-1:0]   d_reg;
    logic signed [H_W-1:0]      h_reg;
    logic signed [SUM_W-1:0]    prod_reg;
    logic signed [COORD_W-1:0]  res_reg [3];
    logic [STATUS_W-1:0]        status_reg;
    logic signed [COORD_W-1:0]  pos_x_reg;
    logic signed [COORD_W-1:0]  pos_y_reg;
    logic signed [COORD_W-1:0]  pos_z_reg;
    logic [STATUS_W-1:0]        rsp_status_reg;

    // Point store
    logic [POINT_W-1:0] mem [MAX_POINTS];

    logic                       req_xfer;
    logic                       out_load;
    logic                       store_full;
    logic                       wr_en;
    logic [IDX_W-1:0]           rd_addr;

    logic [CNT_W-1:0]           segs;
    logic [TOT_W-1:0]           total;
    logic [CNT_W:0]             seg_full;
    logic                       seg_over;

    logic signed [COEF_W-1:0]   p0;
    logic signed [COEF_W-1:0]   p1;
    logic signed [COEF_W-1:0]   p2;
    logic signed [COEF_W-1:0]   p3;
    logic signed [COEF_W-1:0]   coef_a;
    logic signed [COEF_W-1:0]   coef_b;
    logic signed [COEF_W-1:0]   coef_c;
    logic signed [COEF_W-1:0]   coef_d;

    logic signed [COEF_W-1:0]   k_sel;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    sum_shr;
    logic signed [H_W-1:0]      h_new;
    logic signed [COORD_W-1:0]  h_sat;

    // Handshake
    assign req.ready  = (state_reg == S_IDLE);
    assign req_xfer   = req.valid && req.ready;
    assign out_load   = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);
    assign store_full = (count_reg >= CNT_W'(MAX_POINTS));
    assign wr_en      = req_xfer && (req.op == OP_APPEND) && !store_full;
    assign rd_addr    = seg_reg + IDX_W'(rd_cnt_reg);

    assign rsp.valid  = out_valid_reg;
    assign rsp.pos_x  = pos_x_reg;
    assign rsp.pos_y  = pos_y_reg;
    assign rsp.pos_z  = pos_z_reg;
    assign rsp.status = rsp_status_reg;

    // Segment select: t * (count - 3), integer part picks segment
    assign segs     = count_reg - CNT_W'(3);
    assign total    = TOT_W'(t_reg) * TOT_W'(segs);
    assign seg_full = total[TOT_W-1:16];
    assign seg_over = (seg_full >= {1'b0, segs});

    // Basis coefficients for the current axis
    assign p0 = COEF_W'(coord_of(p_reg[0], axis_reg));
    assign p1 = COEF_W'(coord_of(p_reg[1], axis_reg));
    assign p2 = COEF_W'(coord_of(p_reg[2], axis_reg));
    assign p3 = COEF_W'(coord_of(p_reg[3], axis_reg));

    assign coef_a = p3 - p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2;
    assign coef_b = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
    assign coef_c = p2 - p0;
    assign coef_d = p1 <<< 1;

    // Shared multiply-add: round(prod + k * 2^16), half up, by 2^16 or 2^17
    always_comb
    begin
        unique case (step_reg)
            2'd0:    k_sel = b_reg;
            2'd1:    k_sel = c_reg;
            default: k_sel = d_reg;
        endcase
    end

    always_comb
    begin
        if (step_reg == 2'd2)
        begin
            sum     = prod_reg + SUM_W'($signed({k_sel, 16'd0})) + SUM_W'(65536);
            sum_shr = sum >>> 17;
        end
        else
        begin
            sum     = prod_reg + SUM_W'($signed({k_sel, 16'd0})) + SUM_W'(32768);
            sum_shr = sum >>> 16;
        end
        h_new = sum_shr[H_W-1:0];
    end

    // Saturate the running value to 32 bits
    always_comb
    begin
        if (h_reg > H_W'(64'sd2147483647))
            h_sat = 32'sh7FFF_FFFF;
        else if (h_reg < H_W'(-64'sd2147483648))
            h_sat = 32'sh8000_0000;
        else
            h_sat = h_reg[COORD_W-1:0];
    end

    // Point store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[IDX_W-1:0]] <= {req.point_x, req.point_y, req.point_z};
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            cap_reg       <= 1'b0;
            axis_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg <= (state_reg == S_READ);

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_xfer)
                    begin
                        unique case (req.op)
                            OP_APPEND:
                            begin
                                if (!store_full)
                                    count_reg <= count_reg + CNT_W'(1);
                                state_reg <= S_FIN;
                            end
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                                state_reg <= S_FIN;
                            end
                            OP_EVAL:
                            begin
                                if (count_reg < CNT_W'(4))
                                    state_reg <= S_FIN;
                                else
                                    state_reg <= S_SEG;
                            end
                            default:
                                state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_SEG:
                begin
                    rd_cnt_reg <= '0;
                    state_reg  <= S_READ;
                end
                S_READ:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 2'd1;
                    if (rd_cnt_reg == 2'd3)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    axis_reg  <= '0;
                    state_reg <= S_COEF;
                end
                S_COEF:
                begin
                    step_reg  <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                    state_reg <= S_ADD;
                S_ADD:
                begin
                    if (step_reg != 2'd2)
                    begin
                        step_reg  <= step_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                    else if (axis_reg == 2'd2)
                        state_reg <= S_FIN;
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_COEF;
                    end
                end
                S_FIN:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        // Read data shifts in oldest first, P0 ends in slot 0
        if (cap_reg)
        begin
            p_reg[0] <= p_reg[1];
            p_reg[1] <= p_reg[2];
            p_reg[2] <= p_reg[3];
            p_reg[3] <= rd_data_reg;
        end

        if (req_xfer)
        begin
            res_reg[0] <= '0;
            res_reg[1] <= '0;
            res_reg[2] <= '0;
            t_reg      <= (req.param_t > T_ONE) ? T_ONE : req.param_t;
            unique case (req.op)
                OP_APPEND: status_reg <= store_full ? ST_FULL : ST_STORED;
                OP_CLEAR:  status_reg <= ST_CLEARED;
                OP_EVAL:   status_reg <= (count_reg < CNT_W'(4)) ? ST_FEW : ST_POS_OK;
                default:   status_reg <= status_reg;
            endcase
        end

        // Clamp t = 1 to the end of the last segment
        if (state_reg == S_SEG)
        begin
            if (seg_over)
            begin
                seg_reg <= IDX_W'(segs - CNT_W'(1));
                u_reg   <= T_ONE;
            end
            else
            begin
                seg_reg <= seg_full[IDX_W-1:0];
                u_reg   <= {1'b0, total[15:0]};
            end
        end

        if (state_reg == S_COEF)
        begin
            h_reg <= H_W'(coef_a);
            b_reg <= coef_b;
            c_reg <= coef_c;
            d_reg <= coef_d;
        end

        if (state_reg == S_MUL)
            prod_reg <= SUM_W'(h_reg * $signed({1'b0, u_reg}));

        if (state_reg == S_ADD)
            h_reg <= h_new;

        // Next axis after the third step: h_reg holds the unsaturated position
        if (state_reg == S_COEF && step_reg == 2'd2 && axis_reg != 2'd0)
            res_reg[axis_reg - 2'd1] <= h_sat;

        if (out_load)
        begin
            pos_x_reg      <= res_reg[0];
            pos_y_reg      <= res_reg[1];
            pos_z_reg      <= (status_reg == ST_POS_OK && axis_reg == 2'd2) ? h_sat
                                                                          : res_reg[2];
            rsp_status_reg <= status_reg;
        end
    end

endmodule

// ===== tb/catmull_rom_spline_eval_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval_core_tb
// Self-checking bench for the control point store and spline evaluator.
// Commands go in on req with random gaps and results are drained from rsp
// with random stalls. Every accepted command runs through a local model of
// the store and the Catmull-Rom arithmetic. Each result is checked against
// the oldest predicted position and status.
// ----------------------------------------------------------------------------
module catmull_rom_spline_eval_core_tb;
    import crs_pkg::*;

    localparam int DEPTH      = MAX_POINTS_DEF;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_WAIT = 40;
    localparam int RAND_ITEMS = 1700;

    // Opcode with no function; the block ignores it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [STATUS_W-1:0]       status;
    } spline_rsp_t;

    logic clk;
    logic rst_n;

    crs_req_if req ();
    crs_rsp_if rsp ();

    catmull_rom_spline_eval_core #(
        .MAX_POINTS (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Model state: control points and count
    logic signed [COORD_W-1:0] ctrl_x [DEPTH];
    logic signed [COORD_W-1:0] ctrl_y [DEPTH];
    logic signed [COORD_W-1:0] ctrl_z [DEPTH];
    int                        ctrl_count = 0;

    spline_rsp_t pending_pos_q [$];
    spline_rsp_t rsp_exp;

    int fail_count    = 0;
    int idle_cycles   = 0;
    int items_sent    = 0;
    int send_gap_max  = 13;
    int rsp_stall_max = 13;
    int rsp_stall     = 0;
    bit rsp_taken     = 1'b0;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // One axis: Horner form of the basis, round half up, saturate
    function automatic logic signed [COORD_W-1:0] spline_axis(
        input longint p0,
        input longint p1,
        input longint p2,
        input longint p3,
        input longint u
    );
        longint a, b, c, d, h;
        a = -p0 + 3 * p1 - 3 * p2 + p3;
        b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c = p2 - p0;
        d = 2 * p1;
        h = (a * u + b * 65536 + 32768) >>> 16;
        h = (h * u + c * 65536 + 32768) >>> 16;
        h = (h * u + d * 65536 + 65536) >>> 17;
        if (h > 64'sd2147483647)
            h = 64'sd2147483647;
        else if (h < -64'sd2147483648)
            h = -64'sd2147483648;
        return h[COORD_W-1:0];
    endfunction

    // Apply one command to the model and work out its result
    task automatic predict_command(
        input  logic [OP_W-1:0]           op,
        input  logic signed [COORD_W-1:0] x,
        input  logic signed [COORD_W-1:0] y,
        input  logic signed [COORD_W-1:0] z,
        input  logic [T_W-1:0]            t,
        output bit                        has_rsp,
        output spline_rsp_t               r
    );
        int          segs;
        int          seg;
        int          t_cl;
        logic [31:0] total;
        longint      u;
        has_rsp  = 1'b1;
        r.pos_x  = '0;
        r.pos_y  = '0;
        r.pos_z  = '0;
        r.status = ST_POS_OK;
        case (op)
            OP_APPEND:
            begin
                if (ctrl_count < DEPTH)
                begin
                    ctrl_x[ctrl_count] = x;
                    ctrl_y[ctrl_count] = y;
                    ctrl_z[ctrl_count] = z;
                    ctrl_count++;
                    r.status = ST_STORED;
                end
                else
                    r.status = ST_FULL;
            end
            OP_CLEAR:
            begin
                ctrl_count = 0;
                r.status   = ST_CLEARED;
            end
            OP_EVAL:
            begin
                if (ctrl_count < 4)
                    r.status = ST_FEW;
                else
                begin
                    // parameter above one is clamped to one
                    t_cl  = (t > T_ONE) ? int'(T_ONE) : int'(t);
                    segs  = ctrl_count - 3;
                    total = t_cl * segs;
                    seg   = int'(total >> 16);
                    u     = longint'(total & 32'hFFFF);
                    // t of one: last segment at u = 1.0
                    if (seg >= segs)
                    begin
                        seg = segs - 1;
                        u   = 65536;
                    end
                    r.pos_x = spline_axis(ctrl_x[seg], ctrl_x[seg+1], ctrl_x[seg+2],
                                          ctrl_x[seg+3], u);
                    r.pos_y = spline_axis(ctrl_y[seg], ctrl_y[seg+1], ctrl_y[seg+2],
                                          ctrl_y[seg+3], u);
                    r.pos_z = spline_axis(ctrl_z[seg], ctrl_z[seg+1], ctrl_z[seg+2],
                                          ctrl_z[seg+3], u);
                end
            end
            default:
                has_rsp = 1'b0;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Drive one command from a falling edge; returns at the falling edge
    // after its transfer
    task automatic send_command(
        input logic [OP_W-1:0]           op,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic signed [COORD_W-1:0] z,
        input logic [T_W-1:0]            t
    );
        int          gap;
        bit          has_rsp;
        spline_rsp_t r;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.op      <= op;
        req.point_x <= x;
        req.point_y <= y;
        req.point_z <= z;
        req.param_t <= t;
        req.valid   <= 1'b1;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        predict_command(op, x, y, z, t, has_rsp, r);
        if (has_rsp)
            pending_pos_q.insert(pending_pos_q.size(), r);
        if (op != OP_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic signed [COORD_W-1:0] z);
        send_command(OP_APPEND, x, y, z, T_W'($urandom));
    endtask

    task automatic send_eval(input logic [T_W-1:0] t);
        send_command(OP_EVAL, $urandom, $urandom, $urandom, t);
    endtask

    task automatic send_clear();
        send_command(OP_CLEAR, $urandom, $urandom, $urandom, T_W'($urandom));
    endtask

    // Hold the sender until every predicted result has come back
    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_pos_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Coordinate: full range, moderate, or an extreme
    function automatic logic signed [COORD_W-1:0] coord_rand();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4)
            return $urandom;
        else if (k < 8)
            return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
        else
        begin
            case ($urandom_range(0, 4))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return 32'sd0;
                3:       return -32'sd1;
                default: return 32'sd1;
            endcase
        end
    endfunction

    // Parameter: mostly in range, with the ends and values above one
    function automatic logic [T_W-1:0] param_rand();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7)
            return T_W'($urandom_range(0, 65536));
        else if (k == 7)
        begin
            case ($urandom_range(0, 2))
                0:       return T_W'(0);
                1:       return T_W'(65535);
                default: return T_ONE;
            endcase
        end
        else
            return T_W'($urandom_range(65537, 131071));
    endfunction

    // ------------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            rsp_taken = 1'b1;
            if (pending_pos_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result with none expected: x=%0d y=%0d z=%0d st=%0d",
                             $realtime, rsp.pos_x, rsp.pos_y, rsp.pos_z, rsp.status);
            end
            else
            begin
                rsp_exp = pending_pos_q.pop_front();
                if (rsp.pos_x !== rsp_exp.pos_x || rsp.pos_y !== rsp_exp.pos_y ||
                    rsp.pos_z !== rsp_exp.pos_z || rsp.status !== rsp_exp.status)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch exp x=%0d y=%0d z=%0d st=%0d, got x=%0d y=%0d z=%0d st=%0d",
                                 $realtime, rsp_exp.pos_x, rsp_exp.pos_y, rsp_exp.pos_z,
                                 rsp_exp.status, rsp.pos_x, rsp.pos_y, rsp.pos_z,
                                 rsp.status);
                end
            end
        end
    end

    // Result side back-pressure: new stall drawn after each transfer
    always @(negedge clk)
    begin
        if (rsp_taken)
        begin
            rsp_taken = 1'b0;
            rsp_stall = $urandom_range(0, rsp_stall_max);
        end
        if (rsp_stall > 0)
        begin
            rsp.ready <= 1'b0;
            rsp_stall--;
        end
        else
            rsp.ready <= 1'b1;
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((req.valid === 1'b1 && req.ready === 1'b1) ||
            (rsp.valid === 1'b1 && rsp.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty and short stores: too few points, clear, ignored opcode
    task automatic test_empty_store();
        send_eval(T_W'(0));
        send_clear();
        send_command(OP_UNUSED, $urandom, $urandom, $urandom, T_W'($urandom));
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1);
        send_point(32'sd0, 32'sd1, 32'sh7FFF_FFFF);
        send_eval(T_ONE);
    endtask

    // One segment built from extreme points: saturation, ends, clamping
    task automatic test_single_segment();
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_eval(T_W'(0));
        send_eval(T_W'(32768));
        send_eval(T_W'(65535));
        send_eval(T_ONE);
        send_eval(T_W'(131071));
        send_eval(T_W'(65537));
    endtask

    // Three segments: both sides of the first joint, past the second, then evaluate after clear
    task automatic test_segment_joints();
        send_point(32'sh0001_8000, -32'sh0003_0000, 32'sh0000_4000);
        send_point(-32'sh0002_0000, 32'sh0005_0000, 32'sh0007_0000);
        send_eval(T_W'(21845));
        send_eval(T_W'(21846));
        send_eval(T_W'(43691));
        send_clear();
        send_eval(T_W'($urandom_range(0, 65536)));
    endtask

    // Random paths: mostly clear, a run of points, then queries; some noise
    task automatic test_random_paths();
        int seq;
        int n;
        int m;
        int k;
        seq = 0;
        while (items_sent < RAND_ITEMS)
        begin
            send_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 13;
            rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
            if (seq == 2)
                wait_drained();
            if (seq == 1 || $urandom_range(0, 99) < 80)
            begin
                if (seq == 1 || $urandom_range(0, 4) != 0)
                    send_clear();
                // mostly short paths, now and then a full store and overflow
                k = $urandom_range(0, 9);
                if (seq == 1)
                    n = DEPTH + 2;
                else if (k < 6)
                    n = $urandom_range(4, 8);
                else if (k < 9)
                    n = $urandom_range(9, 30);
                else
                    n = $urandom_range(DEPTH - 4, DEPTH + 4);
                repeat (n)
                    send_point(coord_rand(), coord_rand(), coord_rand());
                m = $urandom_range(1, 8);
                repeat (m)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_command(OP_UNUSED, $urandom, $urandom, $urandom,
                                     T_W'($urandom));
                    send_eval(param_rand());
                end
            end
            else
            begin
                m = $urandom_range(1, 6);
                repeat (m)
                    send_command(OP_W'($urandom_range(0, 3)), $urandom, $urandom,
                                 $urandom, T_W'($urandom_range(0, 131071)));
            end
            seq++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.op      = OP_APPEND;
        req.point_x = '0;
        req.point_y = '0;
        req.point_z = '0;
        req.param_t = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_store();
        test_single_segment();
        test_segment_joints();
        wait_drained();
        test_random_paths();

        // Drain and look for stray results
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_pos_q.size() != 0)
        begin
            fail_count++;
            $display("%0d results never arrived", pending_pos_q.size());
        end
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
